// File: rtl/core/random_dfs_maze_walker_assert.svh
// Assertion macros for the maze walker checker.
`ifndef RANDOM_DFS_MAZE_WALKER_ASSERT_SVH
`define RANDOM_DFS_MAZE_WALKER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define RDMW_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define RDMW_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define RDMW_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rdmw_pkg.sv
// Types and constants shared by the maze walker modules.
package rdmw_pkg;

   localparam int GRID_SIZE_DEF = 16;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 16;
   localparam int COORD_W       = 4;

   localparam logic [3:0] ALL_TRIED = 4'hF;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_TRIAL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      EV_CARVED    = 2'd0,
      EV_BLOCKED   = 2'd1,
      EV_BACKTRACK = 2'd2,
      EV_FINISHED  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_CLEAR = 2'd1,
      ST_EVAL  = 2'd2
   } state_type;

endpackage

// File: rtl/core/rdmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdmw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = rdmw_pkg::GRID_SIZE_DEF * rdmw_pkg::GRID_SIZE_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/random_dfs_maze_walker.sv
// Randomized depth-first maze carver: control, visited map and cell stack.
//
// Usage: the req channel takes one beat per command. req_tuser selects start
// (0) or trial (1). A start names the first cell; a trial brings a direction
// that stands in for a random draw. Each beat gives exactly one rsp beat with
// the event code in rsp_tuser and the cell before and after the step.
// Operation: a trial issues its reads of the visited map and of the stack top
// at the accept edge and decides in the evaluate state, once the output
// register is free; its rsp beat is registered, and req_tready rises again
// in the same cycle that it becomes valid, so a new trial is not taken before
// the last one is through. A start sweeps the whole visited map, one entry per
// cycle, writing only the start cell as visited, over 2^(2*clog2(GRID_SIZE))
// entries, 256 for a 16 x 16 grid. One command is in flight.
// Reset: the walker is idle and not running with the current cell at row 0,
// column 0; no sweep runs at reset, since map reads are only used while running
// and every start clears it. The stack needs no clearing either.
// Stalls: the result sits in an output register; while rsp_tready is low the
// next command is still accepted and worked up to its decision, then held.
module random_dfs_maze_walker #(
   parameter int GRID_SIZE = rdmw_pkg::GRID_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] seed_row, [7:4] seed_col, [9:8] direction, [15:10] zero
   input  logic [rdmw_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] op
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] from_row, [7:4] from_col, [11:8] to_row, [15:12] to_col
   output logic [rdmw_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] event_code
   output logic [1:0]                         rsp_tuser
);

   localparam int CW     = $clog2(GRID_SIZE);       // coordinate width
   localparam int VW     = 2 * CW;                  // visited map address width
   localparam int VDEPTH = 1 << VW;
   localparam int CELLS  = GRID_SIZE * GRID_SIZE;
   localparam int SAW    = $clog2(CELLS);           // stack address width
   localparam int DW     = $clog2(CELLS + 1);       // stack depth counter width
   localparam int FW     = rdmw_pkg::COORD_W;
   localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

   // control state
   rdmw_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cur_row_ff, cur_row_in;
   logic [CW-1:0]       cur_col_ff, cur_col_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [3:0]          tried_ff, tried_in;
   logic                running_ff, running_in;

   // trial in flight and clearing sweep
   rdmw_pkg::dir_type   dir_ff, dir_in;
   logic [CW-1:0]       nbr_row_ff, nbr_row_in;
   logic [CW-1:0]       nbr_col_ff, nbr_col_in;
   logic                in_grid_ff, in_grid_in;
   logic [VW-1:0]       clr_ff, clr_in;

   // result register
   logic                          rsp_tvalid_ff;
   logic [rdmw_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [1:0]                    rsp_tuser_ff;

   // request fields
   logic [FW-1:0]       in_row, in_col;
   rdmw_pkg::dir_type   in_dir;
   rdmw_pkg::op_type    in_op;

   logic                accept, out_free, rd_en;
   logic [CW-1:0]       nbr_row_c, nbr_col_c, seed_row_c, seed_col_c;
   logic                in_grid_c;
   logic [CW+FW-1:0]    seed_row_ext, seed_col_ext;
   logic [DW-1:0]       depth_dec_c;
   logic [3:0]          tried_next_c;

   // memory ports
   logic                vis_we;
   logic [VW-1:0]       vis_wa, vis_ra;
   logic [0:0]          vis_wd, vis_rd;
   logic                stk_we;
   logic [SAW-1:0]      stk_wa, stk_ra;
   logic [VW-1:0]       stk_rd;

   // result assembly
   logic                res_fire;
   rdmw_pkg::event_type res_code;
   logic [CW+FW-1:0]    from_row_ext, from_col_ext, to_row_ext, to_col_ext;

   assign in_row = req_tdata[3:0];
   assign in_col = req_tdata[7:4];
   assign in_dir = rdmw_pkg::dir_type'(req_tdata[9:8]);
   assign in_op  = rdmw_pkg::op_type'(req_tuser[0]);

   assign req_tready = (state_ff == rdmw_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rd_en      = accept && (in_op == rdmw_pkg::OP_TRIAL);

   // saturate the start cell into the grid
   assign seed_row_ext = {{CW{1'b0}}, in_row};
   assign seed_col_ext = {{CW{1'b0}}, in_col};
   assign seed_row_c   = (seed_row_ext >= (CW+FW)'(GRID_SIZE)) ? LAST
                                                                : seed_row_ext[CW-1:0];
   assign seed_col_c   = (seed_col_ext >= (CW+FW)'(GRID_SIZE)) ? LAST
                                                                : seed_col_ext[CW-1:0];

   // neighbour of the current cell and whether it lies in the grid
   always_comb begin
      nbr_row_c = cur_row_ff;
      nbr_col_c = cur_col_ff;
      in_grid_c = 1'b1;
      unique case (in_dir)
         rdmw_pkg::DIR_UP: begin
            in_grid_c = (cur_row_ff != '0);
            nbr_row_c = cur_row_ff - CW'(1);
         end
         rdmw_pkg::DIR_RIGHT: begin
            in_grid_c = (cur_col_ff != LAST);
            nbr_col_c = cur_col_ff + CW'(1);
         end
         rdmw_pkg::DIR_DOWN: begin
            in_grid_c = (cur_row_ff != LAST);
            nbr_row_c = cur_row_ff + CW'(1);
         end
         rdmw_pkg::DIR_LEFT: begin
            in_grid_c = (cur_col_ff != '0);
            nbr_col_c = cur_col_ff - CW'(1);
         end
         default: begin
            in_grid_c = 1'b0;
         end
      endcase
   end

   // read the neighbour's visited bit and the stack top at accept
   assign depth_dec_c = depth_ff - DW'(1);
   assign vis_ra      = {nbr_row_c, nbr_col_c};
   assign stk_ra      = depth_dec_c[SAW-1:0];
   assign stk_wa      = depth_ff[SAW-1:0];
   assign tried_next_c = tried_ff | (4'b0001 << dir_ff);

   always_comb begin
      state_in   = state_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      depth_in   = depth_ff;
      tried_in   = tried_ff;
      running_in = running_ff;
      dir_in     = dir_ff;
      nbr_row_in = nbr_row_ff;
      nbr_col_in = nbr_col_ff;
      in_grid_in = in_grid_ff;
      clr_in     = clr_ff;
      vis_we     = 1'b0;
      vis_wa     = {nbr_row_ff, nbr_col_ff};
      vis_wd     = 1'b1;
      stk_we     = 1'b0;
      res_fire   = 1'b0;
      res_code   = rdmw_pkg::EV_FINISHED;

      unique case (state_ff)
         rdmw_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_op == rdmw_pkg::OP_START) begin
                  cur_row_in = seed_row_c;
                  cur_col_in = seed_col_c;
                  depth_in   = '0;
                  tried_in   = '0;
                  running_in = 1'b1;
                  clr_in     = '0;
                  state_in   = rdmw_pkg::ST_CLEAR;
               end else begin
                  dir_in     = in_dir;
                  nbr_row_in = nbr_row_c;
                  nbr_col_in = nbr_col_c;
                  in_grid_in = in_grid_c;
                  state_in   = rdmw_pkg::ST_EVAL;
               end
            end
         end

         rdmw_pkg::ST_CLEAR: begin
            // sweep the map; only the start cell comes out visited
            vis_we = 1'b1;
            vis_wa = clr_ff;
            vis_wd = (clr_ff == {cur_row_ff, cur_col_ff});
            if (clr_ff == VW'(VDEPTH - 1)) begin
               if (out_free) begin
                  res_fire = 1'b1;
                  res_code = rdmw_pkg::EV_CARVED;
                  state_in = rdmw_pkg::ST_IDLE;
               end
            end else begin
               clr_in = clr_ff + VW'(1);
            end
         end

         rdmw_pkg::ST_EVAL: begin
            if (out_free) begin
               res_fire = 1'b1;
               state_in = rdmw_pkg::ST_IDLE;
               if (!running_ff) begin
                  res_code = rdmw_pkg::EV_FINISHED;
               end else if (!in_grid_ff) begin
                  tried_in = tried_next_c;
                  res_code = rdmw_pkg::EV_BLOCKED;
               end else if (vis_rd == 1'b0) begin
                  // carve: push current cell, step into the neighbour
                  if (depth_ff < DW'(CELLS)) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                  end
                  vis_we     = 1'b1;
                  cur_row_in = nbr_row_ff;
                  cur_col_in = nbr_col_ff;
                  tried_in   = '0;
                  res_code   = rdmw_pkg::EV_CARVED;
               end else if (tried_next_c != rdmw_pkg::ALL_TRIED) begin
                  tried_in = tried_next_c;
                  res_code = rdmw_pkg::EV_BLOCKED;
               end else begin
                  tried_in = '0;
                  if (depth_ff == '0) begin
                     running_in = 1'b0;
                     res_code   = rdmw_pkg::EV_FINISHED;
                  end else begin
                     depth_in   = depth_dec_c;
                     cur_row_in = stk_rd[VW-1:CW];
                     cur_col_in = stk_rd[CW-1:0];
                     res_code   = rdmw_pkg::EV_BACKTRACK;
                  end
               end
            end
         end

         default: begin
            state_in = rdmw_pkg::ST_IDLE;
         end
      endcase
   end

   // widen or narrow coordinates to the 4-bit result fields
   assign from_row_ext = {{FW{1'b0}}, cur_row_ff};
   assign from_col_ext = {{FW{1'b0}}, cur_col_ff};
   assign to_row_ext   = {{FW{1'b0}}, cur_row_in};
   assign to_col_ext   = {{FW{1'b0}}, cur_col_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rdmw_pkg::ST_IDLE;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         depth_ff   <= '0;
         tried_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         depth_ff   <= depth_in;
         tried_ff   <= tried_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff     <= dir_in;
      nbr_row_ff <= nbr_row_in;
      nbr_col_ff <= nbr_col_in;
      in_grid_ff <= in_grid_in;
      clr_ff     <= clr_in;
   end

   // output register: load on a new result, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_tdata_ff <= {to_col_ext[FW-1:0], to_row_ext[FW-1:0],
                          from_col_ext[FW-1:0], from_row_ext[FW-1:0]};
         rsp_tuser_ff <= res_code;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   rdmw_ram #(
      .WIDTH (1),
      .DEPTH (VDEPTH)
   ) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_wa),
      .wr_data (vis_wd),
      .rd_en   (rd_en),
      .rd_addr (vis_ra),
      .rd_data (vis_rd)
   );

   rdmw_ram #(
      .WIDTH (VW),
      .DEPTH (CELLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data ({cur_row_ff, cur_col_ff}),
      .rd_en   (rd_en),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

endmodule

// File: rtl/core/rdmw_checker.sv
// Port-level checker for the maze walker, bound to the top level.
`include "random_dfs_maze_walker_assert.svh"

module rdmw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [rdmw_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [0:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rdmw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   // a stalled result beat holds
   `RDMW_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

   // one command in flight: ready drops after every accepted beat
   `RDMW_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second command taken while one in flight")

   // blocked and finished steps leave the current cell where it was
   `RDMW_HOLDS(a_no_move, rsp_tvalid && (rsp_tuser == rdmw_pkg::EV_BLOCKED || rsp_tuser == rdmw_pkg::EV_FINISHED), (rsp_tdata[3:0] == rsp_tdata[11:8]) && (rsp_tdata[7:4] == rsp_tdata[15:12]), "cell moved on a blocked or finished step")

   // reset leaves the walker idle with no result pending
   `RDMW_ALWAYS_NEXT(a_reset_idle, reset, !rsp_tvalid && req_tready, "walker not idle after reset")

endmodule

bind random_dfs_maze_walker rdmw_checker u_rdmw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
